// ===== rtl/gbaa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaa_pkg: shared types and constants for the gray block to ascii art unit
// Field widths, register indexes, block queue entry and the glyph table.
// ----------------------------------------------------------------------------
package gbaa_pkg;

    // default sizing of the line store and the block side
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_ZOOM  = 8;

    // fixed field widths
    localparam int PIX_BITS       = 8;
    localparam int CHAR_BITS      = 7;
    localparam int IMG_W_BITS     = 11;
    localparam int IMG_H_BITS     = 13;
    localparam int ZOOM_BITS      = 4;
    localparam int BAND_BITS      = 12;
    localparam int SUM_BITS       = 14;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [SUM_BITS-1:0]   SUM_MAX    = '1;
    localparam logic [IMG_H_BITS-1:0] MAX_HEIGHT = 13'd4096;

    // register reset values
    localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd512;
    localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd512;
    localparam logic [ZOOM_BITS-1:0]  RST_ZOOM         = 4'd4;

    // glyph table
    localparam int GLYPH_COUNT    = 15;
    localparam int GLYPH_IDX_BITS = 4;

    // block queue depth between sum stage and glyph stage
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ZOOM         = 2'd2
    } cfg_index_t;

    // one finished block on its way to the glyph stage
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                row_end;
    } blk_entry_t;

    // dark to light character ramp
    function automatic logic [CHAR_BITS-1:0] glyph_char(input logic [GLYPH_IDX_BITS-1:0] idx);
        logic [CHAR_BITS-1:0] ch;
        case (idx)
            4'd0:    ch = 7'd77;  // M
            4'd1:    ch = 7'd78;  // N
            4'd2:    ch = 7'd72;  // H
            4'd3:    ch = 7'd81;  // Q
            4'd4:    ch = 7'd36;  // $
            4'd5:    ch = 7'd79;  // O
            4'd6:    ch = 7'd67;  // C
            4'd7:    ch = 7'd63;  // ?
            4'd8:    ch = 7'd55;  // 7
            4'd9:    ch = 7'd62;  // >
            4'd10:   ch = 7'd33;  // !
            4'd11:   ch = 7'd58;  // :
            4'd12:   ch = 7'd45;  // -
            4'd13:   ch = 7'd59;  // ;
            default: ch = 7'd46;  // .
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/gbaa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaa_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gbaa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaa_front: pixel position tracking and block sum accumulation
// Classifies each pixel, adds it into the per-block-column sum store with a
// read-modify-write over two stages and hands finished blocks to the queue.
// ----------------------------------------------------------------------------
module gbaa_front #(
    parameter int MAX_WIDTH = gbaa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ZOOM  = gbaa_pkg::DEF_MAX_ZOOM,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int ZW = $clog2(MAX_ZOOM + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // effective configuration
    input  logic [WW-1:0]                    w_eff,
    input  logic [gbaa_pkg::IMG_H_BITS-1:0]  h_eff,
    input  logic [ZW-1:0]                    z_eff,
    // pixel channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gbaa_pkg::PIX_BITS-1:0]    s_gray_pixel,
    input  logic                             s_frame_start,
    // finished blocks
    output logic                             q_push,
    output gbaa_pkg::blk_entry_t             q_entry,
    input  logic                             q_ready
);

    import gbaa_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int KW  = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
    localparam int PXW = WW + 1;
    localparam int KXW = ZW + 1;
    localparam int BPW = CW + 1 + ZW;
    localparam int HPW = BAND_BITS + 1 + ZW;
    localparam int SXW = SUM_BITS + 1;

    // position counters
    logic [CW-1:0]        pc_reg, pc_next;
    logic [KW-1:0]        cib_reg, cib_next;
    logic [CW-1:0]        bc_reg, bc_next;
    logic [KW-1:0]        rib_reg, rib_next;
    logic [BAND_BITS-1:0] bi_reg, bi_next;
    logic                 done_reg, done_next;

    // clearing pass after reset
    logic                 clr_active_reg;
    logic [CW-1:0]        clr_addr_reg;

    // accumulate stage
    logic                 b_valid_reg;
    logic [PIX_BITS-1:0]  b_pix_reg;
    logic                 b_wr_reg;
    logic                 b_first_reg;
    logic                 b_emit_reg;
    logic                 b_row_end_reg;
    logic [CW-1:0]        b_slot_reg;
    logic                 b_byp_reg;
    logic [SUM_BITS-1:0]  b_byp_data_reg;

    logic [CW-1:0]        pc_e, bc_e;
    logic [KW-1:0]        cib_e, rib_e;
    logic [BAND_BITS-1:0] bi_e;
    logic                 done_e;
    logic                 cib_last, rib_last, line_last;
    logic [BPW-1:0]       blk_p1, blk_p2;
    logic [HPW-1:0]       band_p1, band_p2;
    logic                 blk_ok, blk_last, band_ok, band_last;
    logic                 pix_valid, pix_first, pix_emit;
    logic                 accept;
    logic                 b_go;
    logic [SUM_BITS-1:0]  ram_rdata, b_base, b_sum;
    logic [SXW-1:0]       b_sum_wide;
    logic                 acc_we;
    logic                 ram_we;
    logic [CW-1:0]        ram_waddr;
    logic [SUM_BITS-1:0]  ram_wdata;

    // frame start clears the counters before the pixel is used
    always_comb begin
        pc_e   = s_frame_start ? '0 : pc_reg;
        cib_e  = s_frame_start ? '0 : cib_reg;
        bc_e   = s_frame_start ? '0 : bc_reg;
        rib_e  = s_frame_start ? '0 : rib_reg;
        bi_e   = s_frame_start ? '0 : bi_reg;
        done_e = s_frame_start ? 1'b0 : done_reg;
    end

    // wrap tests against the current limits
    assign cib_last  = (KXW'(cib_e) + KXW'(1)) >= KXW'(z_eff);
    assign rib_last  = (KXW'(rib_e) + KXW'(1)) >= KXW'(z_eff);
    assign line_last = (PXW'(pc_e) + PXW'(1)) >= PXW'(w_eff);

    // whole block tests: block b exists while (b+1)*zoom fits the width
    assign blk_p1    = (BPW'(bc_e) + BPW'(1)) * BPW'(z_eff);
    assign blk_p2    = (BPW'(bc_e) + BPW'(2)) * BPW'(z_eff);
    assign blk_ok    = blk_p1 <= BPW'(w_eff);
    assign blk_last  = blk_ok && (BPW'(w_eff) < blk_p2);

    assign band_p1   = (HPW'(bi_e) + HPW'(1)) * HPW'(z_eff);
    assign band_p2   = (HPW'(bi_e) + HPW'(2)) * HPW'(z_eff);
    assign band_ok   = band_p1 <= HPW'(h_eff);
    assign band_last = HPW'(h_eff) < band_p2;

    assign pix_valid = !done_e && band_ok && blk_ok;
    assign pix_first = (rib_e == '0) && (cib_e == '0);
    assign pix_emit  = pix_valid && rib_last && cib_last;

    // handshake
    assign b_go    = !b_emit_reg || q_ready;
    assign s_ready = !clr_active_reg && (!b_valid_reg || b_go);
    assign accept  = s_valid && s_ready;

    // counter advance
    always_comb begin
        pc_next   = pc_e;
        cib_next  = cib_e;
        bc_next   = bc_e;
        rib_next  = rib_e;
        bi_next   = bi_e;
        done_next = done_e;
        if (line_last) begin
            pc_next  = '0;
            cib_next = '0;
            bc_next  = '0;
            if (rib_last) begin
                rib_next = '0;
                if (!done_e) begin
                    if (band_last) begin
                        done_next = 1'b1;
                    end else begin
                        bi_next = bi_e + BAND_BITS'(1);
                    end
                end
            end else begin
                rib_next = rib_e + KW'(1);
            end
        end else begin
            pc_next = pc_e + CW'(1);
            if (cib_last) begin
                cib_next = '0;
                bc_next  = bc_e + CW'(1);
            end else begin
                cib_next = cib_e + KW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            cib_reg  <= '0;
            bc_reg   <= '0;
            rib_reg  <= '0;
            bi_reg   <= '0;
            done_reg <= 1'b0;
        end else if (accept) begin
            pc_reg   <= pc_next;
            cib_reg  <= cib_next;
            bc_reg   <= bc_next;
            rib_reg  <= rib_next;
            bi_reg   <= bi_next;
            done_reg <= done_next;
        end
    end

    // sum store clearing pass, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + CW'(1);
        end
    end

    // accumulate: first pixel of a block overwrites, the rest add and saturate
    assign b_base     = b_first_reg ? '0 : (b_byp_reg ? b_byp_data_reg : ram_rdata);
    assign b_sum_wide = SXW'(b_base) + SXW'(b_pix_reg);
    assign b_sum      = (b_sum_wide > SXW'(SUM_MAX)) ? SUM_MAX : b_sum_wide[SUM_BITS-1:0];
    assign acc_we     = b_valid_reg && b_wr_reg && b_go;

    assign ram_we    = clr_active_reg || acc_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : b_slot_reg;
    assign ram_wdata = clr_active_reg ? '0 : b_sum;

    // control of the accumulate stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= s_valid;
        end
    end

    // payload of the accumulate stage, with forwarding of a write to the same slot
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pix_reg      <= s_gray_pixel;
            b_wr_reg       <= pix_valid;
            b_first_reg    <= pix_first;
            b_emit_reg     <= pix_emit;
            b_row_end_reg  <= blk_last;
            b_slot_reg     <= bc_e;
            b_byp_reg      <= acc_we && (b_slot_reg == bc_e);
            b_byp_data_reg <= b_sum;
        end
    end

    gbaa_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (bc_e),
        .rdata (ram_rdata)
    );

    // finished block transfer to the queue
    assign q_push          = b_valid_reg && b_emit_reg && b_go;
    assign q_entry.sum     = b_sum;
    assign q_entry.row_end = b_row_end_reg;

endmodule

// ===== rtl/gbaa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaa_queue: short block queue
// Decouples the sum stage from the glyph stage so each can stall alone.
// ----------------------------------------------------------------------------
module gbaa_queue #(
    parameter int DEPTH = gbaa_pkg::QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  gbaa_pkg::blk_entry_t push_entry,
    output logic                 push_ready,
    input  logic                 pop,
    output logic                 pop_valid,
    output gbaa_pkg::blk_entry_t pop_entry
);

    import gbaa_pkg::*;

    blk_entry_t    slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = count_reg != NW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/gbaa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaa_back: glyph selection and character pair output
// Divides a block sum by 18*zoom*zoom through a bank of threshold compares,
// looks up the glyph and sends it twice on the result channel.
// ----------------------------------------------------------------------------
module gbaa_back #(
    parameter int MAX_ZOOM = gbaa_pkg::DEF_MAX_ZOOM,
    localparam int ZW = $clog2(MAX_ZOOM + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ZW-1:0]                   z_eff,
    // finished blocks
    input  logic                            q_valid,
    input  gbaa_pkg::blk_entry_t            q_entry,
    output logic                            q_pop,
    // character channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gbaa_pkg::CHAR_BITS-1:0]  m_char_code,
    output logic                            m_pair_last,
    output logic                            m_row_end
);

    import gbaa_pkg::*;

    localparam int DW   = 2 * ZW + 5;
    localparam int TW   = DW + GLYPH_IDX_BITS;
    localparam int CMPW = (TW > SUM_BITS) ? TW : SUM_BITS;

    logic [DW-1:0]             zsq;
    logic [DW-1:0]             div_reg;
    logic [GLYPH_IDX_BITS-1:0] idx;
    logic                      out_free;

    logic                      m_valid_reg;
    logic [CHAR_BITS-1:0]      m_char_code_reg;
    logic                      m_pair_last_reg;
    logic                      m_row_end_reg;
    logic                      second_reg;
    logic                      held_row_end_reg;

    // block divisor 18*zoom*zoom, registered from the clamped zoom value
    assign zsq = DW'(z_eff) * DW'(z_eff);

    always_ff @(posedge aclk) begin
        div_reg <= (zsq << 4) + (zsq << 1);
    end

    // quotient by threshold compares, saturating at the last glyph
    always_comb begin
        idx = '0;
        for (int k = 1; k < GLYPH_COUNT; k++) begin
            if (CMPW'(q_entry.sum) >= CMPW'(k) * CMPW'(div_reg)) begin
                idx = GLYPH_IDX_BITS'(k);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = out_free && !second_reg && q_valid;

    // output register: first copy from the queue, second copy from the hold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
        end else if (out_free) begin
            if (second_reg) begin
                m_valid_reg <= 1'b1;
                second_reg  <= 1'b0;
            end else begin
                m_valid_reg <= q_valid;
                second_reg  <= q_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (second_reg) begin
                m_pair_last_reg <= 1'b1;
                m_row_end_reg   <= held_row_end_reg;
            end else if (q_valid) begin
                m_char_code_reg  <= glyph_char(idx);
                m_pair_last_reg  <= 1'b0;
                m_row_end_reg    <= 1'b0;
                held_row_end_reg <= q_entry.row_end;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_pair_last = m_pair_last_reg;
    assign m_row_end   = m_row_end_reg;

endmodule

// ===== rtl/gray_block_to_ascii_art_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_block_to_ascii_art_unit: grayscale block averager to ascii art
// Sums zoom-by-zoom pixel blocks and emits one glyph per block, twice.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_gray_pixel, s_frame_start
//   m_      | out       | m_valid / m_ready  | m_char_code, m_pair_last, m_row_end
//   cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data
//
// One pixel a cycle enters the sum stage while s_ready is high; the sum
// store is read and written once per pixel through its single read and
// single write port. Each finished block gives two characters, so with
// zoom 1 the result channel paces the pixel side, else one pixel a cycle.
// After reset s_ready is low while all MAX_WIDTH sum store entries clear.
// A stalled result channel fills the queue; a block facing it holds s_ready low.
// ----------------------------------------------------------------------------
module gray_block_to_ascii_art_unit #(
    parameter int MAX_WIDTH = gbaa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ZOOM  = gbaa_pkg::DEF_MAX_ZOOM
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [gbaa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gbaa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // pixel channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gbaa_pkg::PIX_BITS-1:0]       s_gray_pixel,
    input  logic                                s_frame_start,
    // character channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gbaa_pkg::CHAR_BITS-1:0]      m_char_code,
    output logic                                m_pair_last,
    output logic                                m_row_end
);

    import gbaa_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int ZW = $clog2(MAX_ZOOM + 1);
    localparam int WC = (IMG_W_BITS > WW) ? IMG_W_BITS : WW;
    localparam int ZC = (ZOOM_BITS > ZW) ? ZOOM_BITS : ZW;

    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_H_BITS-1:0] image_height_reg;
    logic [ZOOM_BITS-1:0]  zoom_reg;

    logic [WC-1:0]         w_ext, w_clamp;
    logic [ZC-1:0]         z_ext, z_clamp;
    logic [WW-1:0]         w_eff;
    logic [IMG_H_BITS-1:0] h_eff;
    logic [ZW-1:0]         z_eff;

    logic                  q_push, q_push_ready, q_pop, q_valid;
    blk_entry_t            q_push_entry, q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            zoom_reg         <= RST_ZOOM;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_BITS-1:0];
                CFG_ZOOM:         zoom_reg         <= cfg_data[ZOOM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp register values to their working ranges
    always_comb begin
        w_ext = WC'(image_width_reg);
        if (w_ext == '0) begin
            w_clamp = WC'(1);
        end else if (w_ext > WC'(MAX_WIDTH)) begin
            w_clamp = WC'(MAX_WIDTH);
        end else begin
            w_clamp = w_ext;
        end

        if (image_height_reg == '0) begin
            h_eff = IMG_H_BITS'(1);
        end else if (image_height_reg > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end else begin
            h_eff = image_height_reg;
        end

        z_ext = ZC'(zoom_reg);
        if (z_ext == '0) begin
            z_clamp = ZC'(1);
        end else if (z_ext > ZC'(MAX_ZOOM)) begin
            z_clamp = ZC'(MAX_ZOOM);
        end else begin
            z_clamp = z_ext;
        end
    end

    assign w_eff = w_clamp[WW-1:0];
    assign z_eff = z_clamp[ZW-1:0];

    gbaa_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ZOOM  (MAX_ZOOM)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .w_eff         (w_eff),
        .h_eff         (h_eff),
        .z_eff         (z_eff),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_gray_pixel  (s_gray_pixel),
        .s_frame_start (s_frame_start),
        .q_push        (q_push),
        .q_entry       (q_push_entry),
        .q_ready       (q_push_ready)
    );

    gbaa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_head)
    );

    gbaa_back #(
        .MAX_ZOOM (MAX_ZOOM)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .z_eff       (z_eff),
        .q_valid     (q_valid),
        .q_entry     (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_pair_last (m_pair_last),
        .m_row_end   (m_row_end)
    );

endmodule

// ===== rtl/gbaa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaa_checker: port level checks for the gray block to ascii art unit
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module gbaa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                cfg_wr_en,
    input logic [gbaa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [gbaa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [gbaa_pkg::PIX_BITS-1:0]       s_gray_pixel,
    input logic                                s_frame_start,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [gbaa_pkg::CHAR_BITS-1:0]      m_char_code,
    input logic                                m_pair_last,
    input logic                                m_row_end
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_char_code)
                                   && $stable(m_pair_last) && $stable(m_row_end)))
        else $error("result changed while stalled");

    // the first copy of a block is followed at once by its second copy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_pair_last) |=>
            (m_valid && m_pair_last && (m_char_code == $past(m_char_code))))
        else $error("second copy of a block missing or different");

    // end of text row only on the second copy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_row_end) |-> m_pair_last)
        else $error("row end on a first copy");

    // the sum store clearing pass blocks pixel transfers after reset
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("pixel accepted during clearing pass");

endmodule

bind gray_block_to_ascii_art_unit gbaa_checker u_gbaa_checker (.*);

// ===== tb/gray_block_to_ascii_art_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_block_to_ascii_art_unit_tb: self-checking bench for the ascii art unit
// Streams grayscale frames through the pixel channel, predicts every glyph
// pair from its own block-sum model and checks each character transfer in
// order. Random gaps on the pixel side and random stalls on the character
// side; registers are only changed once the unit has drained.
// ----------------------------------------------------------------------------
module gray_block_to_ascii_art_unit_tb;
    import gbaa_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PIXELS = 900;
    localparam int WIDE_PIXELS   = 96;
    localparam int LEVEL_STEP    = 18;

    // one character as it should leave the unit
    typedef struct {
        logic [CHAR_BITS-1:0] code;
        logic                 pair_last;
        logic                 row_end;
    } glyph_out_t;

    // block-sum predictor and in-order character check
    class glyph_board;
        logic [IMG_W_BITS-1:0] image_width;
        logic [IMG_H_BITS-1:0] image_height;
        logic [ZOOM_BITS-1:0]  zoom;
        logic [SUM_BITS-1:0]   block_sum [DEF_MAX_WIDTH];
        logic [9:0]            pixel_col;
        logic [2:0]            row_in_band;
        logic [BAND_BITS-1:0]  band;
        logic [2:0]            col_in_block;
        logic [9:0]            block_col;
        logic                  frame_done;
        string                 ramp = "MNHQ$OC?7>!:-;.";
        glyph_out_t            glyphs_due [$];
        int                    errors;

        function new();
            image_width  = RST_IMAGE_WIDTH;
            image_height = RST_IMAGE_HEIGHT;
            zoom         = RST_ZOOM;
            foreach (block_sum[k]) block_sum[k] = '0;
            restart_frame();
            errors = 0;
        endfunction

        function void restart_frame();
            pixel_col    = '0;
            row_in_band  = '0;
            band         = '0;
            col_in_block = '0;
            block_col    = '0;
            frame_done   = 1'b0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  image_width  = value[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height = value[IMG_H_BITS-1:0];
                CFG_ZOOM:         zoom         = value[ZOOM_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return glyphs_due.size();
        endfunction

        // accumulate one accepted pixel, queue a glyph pair on a block corner
        function void take_pixel(logic [PIX_BITS-1:0] pix, logic first);
            int unsigned z, w, h, blocks, bands, acc, level;
            byte         glyph;
            glyph_out_t  item;
            z = (zoom == 0) ? 1 : ((zoom > DEF_MAX_ZOOM) ? DEF_MAX_ZOOM : zoom);
            w = (image_width == 0) ? 1 :
                ((image_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : image_width);
            h = (image_height == 0) ? 1 :
                ((image_height > MAX_HEIGHT) ? MAX_HEIGHT : image_height);
            blocks = w / z;
            bands  = h / z;
            if (first) restart_frame();

            // sum into the block column, first pixel of a block overwrites
            if (!frame_done && band < bands && block_col < blocks) begin
                if (row_in_band == 0 && col_in_block == 0) acc = pix;
                else acc = block_sum[block_col] + pix;
                if (acc > SUM_MAX) acc = SUM_MAX;
                block_sum[block_col] = acc[SUM_BITS-1:0];
                if (row_in_band + 1 >= z && col_in_block + 1 >= z) begin
                    level = acc / (LEVEL_STEP * z * z);
                    if (level >= GLYPH_COUNT) level = GLYPH_COUNT - 1;
                    glyph          = ramp[level];
                    item.code      = glyph[CHAR_BITS-1:0];
                    item.pair_last = 1'b0;
                    item.row_end   = 1'b0;
                    glyphs_due.push_back(item);
                    item.pair_last = 1'b1;
                    item.row_end   = (block_col + 1 == blocks);
                    glyphs_due.push_back(item);
                end
            end

            // step the raster position
            if (pixel_col + 1 >= w) begin
                pixel_col    = '0;
                col_in_block = '0;
                block_col    = '0;
                if (row_in_band + 1 >= z) begin
                    row_in_band = '0;
                    if (!frame_done) begin
                        if (band + 1 >= bands) frame_done = 1'b1;
                        else band = BAND_BITS'(band + 1);
                    end
                end else begin
                    row_in_band = 3'(row_in_band + 1);
                end
            end else begin
                pixel_col = 10'(pixel_col + 1);
                if (col_in_block + 1 >= z) begin
                    col_in_block = '0;
                    block_col    = 10'(block_col + 1);
                end else begin
                    col_in_block = 3'(col_in_block + 1);
                end
            end
        endfunction

        // compare one character transfer with the oldest queued glyph
        function void match_glyph(logic [CHAR_BITS-1:0] code, logic last, logic rend);
            glyph_out_t want;
            if (glyphs_due.size() == 0) begin
                $error("char_code %0d arrived with no glyph pending", code);
                errors++;
                return;
            end
            want = glyphs_due.pop_front();
            if (code !== want.code) begin
                $error("char_code: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (last !== want.pair_last) begin
                $error("pair_last: expected %0d, actual %0d", want.pair_last, last);
                errors++;
            end
            if (rend !== want.row_end) begin
                $error("row_end: expected %0d, actual %0d", want.row_end, rend);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [PIX_BITS-1:0]       s_gray_pixel;
    logic                      s_frame_start;
    logic                      m_valid;
    logic                      m_ready;
    logic [CHAR_BITS-1:0]      m_char_code;
    logic                      m_pair_last;
    logic                      m_row_end;

    glyph_board board;
    bit         pixel_gaps;
    bit         char_stalls;
    int         cycle_count;

    gray_block_to_ascii_art_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_gray_pixel  (s_gray_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_pair_last   (m_pair_last),
        .m_row_end     (m_row_end)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run-away guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // observe both channels on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.take_pixel(s_gray_pixel, s_frame_start);
            if (m_valid && m_ready) board.match_glyph(m_char_code, m_pair_last, m_row_end);
        end
    end

    // character sink with a random stall before each transfer
    initial begin : char_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = char_stalls ? $urandom_range(0, 15) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // present one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic first);
        int gap;
        gap = pixel_gaps ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_gray_pixel  <= pix;
        s_frame_start <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold the pixel side until every glyph has left and the pipe is empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        board.set_register(idx, value[CFG_DATA_BITS-1:0]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h, input int unsigned z);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_ZOOM, z);
    endtask

    // stimulus
    initial begin : stimulus
        int unsigned         w, h, z, zc, n, cut, stray, style, mode, taken, i;
        int                  v;
        logic [PIX_BITS-1:0] base, pix;
        board         = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_IMAGE_WIDTH;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_gray_pixel  = '0;
        s_frame_start = 1'b0;
        pixel_gaps    = 1'b1;
        char_stalls   = 1'b1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single 2x2 blocks: mid grey, full white, full black
        set_image(2, 2, 2);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        for (i = 0; i < 4; i++) send_pixel(8'hFF, i == 0);
        for (i = 0; i < 4; i++) send_pixel(8'h00, i == 0);
        // pixels past the last band are dropped
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);

        // zero registers behave as one
        set_image(0, 0, 0);
        send_pixel(8'd200, 1'b1);

        // image shorter than one block gives nothing
        set_image(3, 1, 2);
        for (i = 0; i < 3; i++) send_pixel(8'hFF, i == 0);

        // zoom drop inside a block pushes the level past the table end
        set_image(2, 2, 2);
        for (i = 0; i < 3; i++) send_pixel(8'hFF, i == 0);
        settle();
        write_reg(CFG_ZOOM, 1);
        send_pixel(8'hFF, 1'b0);

        // start of the widest row, register values above the limits saturate
        set_image(2047, 8191, 1);
        for (i = 0; i < WIDE_PIXELS; i++) begin
            send_pixel(PIX_BITS'($urandom_range(0, 255)), i == 0);
        end

        // random frames, mostly whole, some cut, padded or disturbed
        taken = 0;
        while (taken < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       z = 0;
                1:       z = $urandom_range(9, 15);
                2, 3:    z = 1;
                4:       z = DEF_MAX_ZOOM;
                default: z = $urandom_range(2, 7);
            endcase
            zc = (z == 0) ? 1 : ((z > DEF_MAX_ZOOM) ? DEF_MAX_ZOOM : z);
            w  = zc * $urandom_range(1, (zc > 4) ? 2 : 4);
            if ($urandom_range(0, 2) == 0) w = w + $urandom_range(0, zc - 1);
            h  = zc * $urandom_range(1, (zc > 4) ? 2 : 3);
            if ($urandom_range(0, 2) == 0) h = h + $urandom_range(0, zc - 1);
            if ($urandom_range(0, 11) == 0) w = $urandom_range(1, zc);
            if ($urandom_range(0, 11) == 0) h = $urandom_range(1, zc);
            set_image(w, h, z);

            pixel_gaps  = ($urandom_range(0, 3) != 0);
            char_stalls = ($urandom_range(0, 3) != 0);
            n     = w * h;
            style = $urandom_range(0, 9);
            mode  = $urandom_range(0, 2);
            base  = PIX_BITS'($urandom_range(0, 255));
            cut   = (style == 6 && n > 1) ? $urandom_range(1, n - 1) : n;
            stray = (style == 9 && n > 1) ? $urandom_range(1, n - 1) : 0;

            for (i = 0; i < cut; i++) begin
                // zoom change halfway through the frame
                if (style == 8 && i > 0 && i == n / 2) begin
                    settle();
                    write_reg(CFG_ZOOM, $urandom_range(1, DEF_MAX_ZOOM));
                end
                case (mode)
                    0: pix = PIX_BITS'($urandom_range(0, 255));
                    1: begin
                        v   = int'(base) + int'($urandom_range(0, 40)) - 20;
                        pix = (v < 0) ? 8'h00 : ((v > 255) ? 8'hFF : v[7:0]);
                    end
                    default: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                send_pixel(pix, i == 0 || i == stray);
            end
            taken += cut;

            // trailing pixels after the frame
            if (style == 7) begin
                repeat ($urandom_range(1, 6)) begin
                    send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'b0);
                end
            end
        end

        settle();
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gbaa_pkg.sv
rtl/gbaa_ram.sv
rtl/gbaa_front.sv
rtl/gbaa_queue.sv
rtl/gbaa_back.sv
rtl/gray_block_to_ascii_art_unit.sv
rtl/gbaa_checker.sv
tb/gray_block_to_ascii_art_unit_tb.sv
